// ----- hdl/triangle_perimeter_area_macros.svh -----
// Assertion helpers used by the top-level RTL file.
`ifndef TRIANGLE_PERIMETER_AREA_MACROS_SVH
`define TRIANGLE_PERIMETER_AREA_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define TPA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tpa: same-cycle check failed");

// Next-cycle implication, disabled in reset.
`define TPA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tpa: next-cycle check failed");

`endif

// ----- hdl/tpa_pkg.sv -----
package tpa_pkg;

  localparam int COORD_BITS_DEF = 12;

  localparam int SIDE_W  = 15;
  localparam int PERIM_W = 17;
  localparam int AREA_W  = 27;
  localparam int DIST_W  = 14;

  localparam logic [31:0] SIDE_MAX  = 32'd32767;
  localparam logic [31:0] PERIM_MAX = 32'd131071;
  localparam logic [31:0] AREA_MAX  = 32'd134217727;
  localparam logic [31:0] DIST_MAX  = 32'd16383;

  // Heron product saturates at 64 bits before its root.
  localparam int AREA_RAD_W   = 64;
  localparam int AREA_ROOT_W  = AREA_RAD_W / 2;
  localparam int PROD_W       = 96;
  localparam int HERON_STAGES = 4;

  localparam int LANES = 6;

endpackage

// ----- hdl/tpa_sqrt_cell.sv -----
module tpa_sqrt_cell #(
  parameter int RAD_W = 30
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [RAD_W-1:0]     rad_i,
  input  logic [RAD_W/2+1:0]   rem_i,
  input  logic [RAD_W/2-1:0]   root_i,
  output logic [RAD_W-1:0]     rad_o,
  output logic [RAD_W/2+1:0]   rem_o,
  output logic [RAD_W/2-1:0]   root_o
);

  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 2;

  logic [REM_W+1:0]  cur;
  logic [REM_W+1:0]  trial;
  logic              take;
  logic [RAD_W-1:0]  rad_nxt;
  logic [REM_W-1:0]  rem_nxt;
  logic [ROOT_W-1:0] root_nxt;
  logic [RAD_W-1:0]  rad_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;

  // Bring down the next two radicand bits and try the next root bit.
  always_comb begin
    cur      = {rem_i, rad_i[RAD_W-1 -: 2]};
    trial    = (REM_W+2)'({root_i, 2'b01});
    take     = (cur >= trial);
    rem_nxt  = take ? REM_W'(cur - trial) : REM_W'(cur);
    root_nxt = {root_i[ROOT_W-2:0], take};
    rad_nxt  = rad_i << 2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= rad_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign rad_o  = rad_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;

endmodule

// ----- hdl/tpa_sqrt_chain.sv -----
module tpa_sqrt_chain #(
  parameter int RAD_W = 30
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [RAD_W-1:0]     rad_i,
  output logic [RAD_W/2-1:0]   root_o
);

  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 2;

  logic [RAD_W-1:0]  rad_w  [ROOT_W+1];
  logic [REM_W-1:0]  rem_w  [ROOT_W+1];
  logic [ROOT_W-1:0] root_w [ROOT_W+1];

  assign rad_w[0]  = rad_i;
  assign rem_w[0]  = '0;
  assign root_w[0] = '0;

  // One root bit per cell, most significant first.
  for (genvar i = 0; i < ROOT_W; i++) begin : g_cell
    tpa_sqrt_cell #(.RAD_W(RAD_W)) u_cell (
      .clk    (clk),
      .en     (en),
      .rad_i  (rad_w[i]),
      .rem_i  (rem_w[i]),
      .root_i (root_w[i]),
      .rad_o  (rad_w[i+1]),
      .rem_o  (rem_w[i+1]),
      .root_o (root_w[i+1])
    );
  end

  assign root_o = root_w[ROOT_W];

endmodule

// ----- hdl/tpa_heron.sv -----
module tpa_heron #(
  parameter int LEN_W = 15
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [LEN_W-1:0]     side_ab,
  input  logic [LEN_W-1:0]     side_ac,
  input  logic [LEN_W-1:0]     side_bc,
  output logic [LEN_W+1:0]     perim_o,
  output logic [tpa_pkg::AREA_RAD_W-1:0] prod_o
);

  import tpa_pkg::*;

  localparam int SUM_W = LEN_W + 2;

  logic [SUM_W-1:0]     p_c;
  logic [SUM_W-1:0]     f_c [3];
  logic [SUM_W-1:0]     p1_r, p2_r, p3_r, p4_r;
  logic [SUM_W-1:0]     f_r [3];
  logic [2*SUM_W-1:0]   m1_r, m2_r;
  logic [3*SUM_W-1:0]   lo_r, hi_r;
  logic [PROD_W-1:0]    full_c;
  logic [AREA_RAD_W-1:0] prod_r;

  // Clamp each factor P - 2s at zero.
  always_comb begin
    p_c = SUM_W'(side_ab) + SUM_W'(side_ac) + SUM_W'(side_bc);
    f_c[0] = (p_c > (SUM_W'(side_ab) << 1)) ? p_c - (SUM_W'(side_ab) << 1) : '0;
    f_c[1] = (p_c > (SUM_W'(side_ac) << 1)) ? p_c - (SUM_W'(side_ac) << 1) : '0;
    f_c[2] = (p_c > (SUM_W'(side_bc) << 1)) ? p_c - (SUM_W'(side_bc) << 1) : '0;
  end

  // Split the wide product into two partial products, then merge and saturate.
  assign full_c = PROD_W'(lo_r) + (PROD_W'(hi_r) << SUM_W);

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r   <= p_c;
      f_r    <= f_c;
      p2_r   <= p1_r;
      m1_r   <= (2*SUM_W)'(p1_r) * (2*SUM_W)'(f_r[0]);
      m2_r   <= (2*SUM_W)'(f_r[1]) * (2*SUM_W)'(f_r[2]);
      p3_r   <= p2_r;
      lo_r   <= (3*SUM_W)'(m1_r) * (3*SUM_W)'(m2_r[SUM_W-1:0]);
      hi_r   <= (3*SUM_W)'(m1_r) * (3*SUM_W)'(m2_r[2*SUM_W-1:SUM_W]);
      p4_r   <= p3_r;
      prod_r <= (|full_c[PROD_W-1:AREA_RAD_W]) ? '1 : full_c[AREA_RAD_W-1:0];
    end
  end

  assign perim_o = p4_r;
  assign prod_o  = prod_r;

endmodule

// ----- hdl/triangle_perimeter_area.sv -----
// Triangle measure pipeline: takes one triangle (three points, signed whole-unit
// coordinates) per cycle and returns side lengths and corner distances from the
// origin in quarter units, the perimeter, and the Heron area in sixteenths of a
// square unit, each saturated to its field. Throughput is one triangle per cycle.
// The pipeline has one squaring stage, COORD_BITS+3 square-root cells for the
// lengths, four Heron multiply stages, 32 square-root cells for the area and one
// output register. A held result stalls the whole pipeline.
`include "triangle_perimeter_area_macros.svh"

module triangle_perimeter_area #(
  parameter int COORD_BITS = tpa_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_BITS-1:0]  in_ax,
  input  logic signed [COORD_BITS-1:0]  in_ay,
  input  logic signed [COORD_BITS-1:0]  in_bx,
  input  logic signed [COORD_BITS-1:0]  in_by,
  input  logic signed [COORD_BITS-1:0]  in_cx,
  input  logic signed [COORD_BITS-1:0]  in_cy,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tpa_pkg::SIDE_W-1:0]    out_side_ab,
  output logic [tpa_pkg::SIDE_W-1:0]    out_side_ac,
  output logic [tpa_pkg::SIDE_W-1:0]    out_side_bc,
  output logic [tpa_pkg::PERIM_W-1:0]   out_perimeter,
  output logic [tpa_pkg::AREA_W-1:0]    out_area,
  output logic [tpa_pkg::DIST_W-1:0]    out_dist_a,
  output logic [tpa_pkg::DIST_W-1:0]    out_dist_b,
  output logic [tpa_pkg::DIST_W-1:0]    out_dist_c
);

  import tpa_pkg::*;

  localparam int LEN_RAD_W  = 2*COORD_BITS + 6;
  localparam int LEN_ROOT_W = LEN_RAD_W / 2;
  localparam int SUM_W      = LEN_ROOT_W + 2;
  localparam int DLY_N      = HERON_STAGES + AREA_ROOT_W;
  localparam int PIPE_N     = 1 + LEN_ROOT_W + DLY_N;

  logic                          en;
  logic [PIPE_N-1:0]             vld_r;
  logic                          out_valid_r;

  logic signed [COORD_BITS:0]    dx_c [LANES];
  logic signed [COORD_BITS:0]    dy_c [LANES];
  logic [COORD_BITS-1:0]         adx_c [LANES];
  logic [COORD_BITS-1:0]         ady_c [LANES];
  logic [LEN_RAD_W-1:0]          rad_c [LANES];
  logic [LEN_RAD_W-1:0]          rad_r [LANES];
  logic [LEN_ROOT_W-1:0]         len_root [LANES];
  logic [LEN_ROOT_W-1:0]         len_d_r [LANES][DLY_N];

  logic [SUM_W-1:0]              perim_h;
  logic [AREA_RAD_W-1:0]         prod_h;
  logic [SUM_W-1:0]              perim_d_r [AREA_ROOT_W];
  logic [AREA_ROOT_W-1:0]        area_root;
  logic [31:0]                   area_q;
  logic [31:0]                   len_q [LANES];
  logic [31:0]                   perim_q;

  logic [SIDE_W-1:0]             side_ab_r, side_ac_r, side_bc_r;
  logic [PERIM_W-1:0]            perim_r;
  logic [AREA_W-1:0]             area_r;
  logic [DIST_W-1:0]             dist_a_r, dist_b_r, dist_c_r;

  // Advance everything unless a result is held at the output.
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  always_comb begin
    dx_c[0] = (COORD_BITS+1)'(in_bx) - (COORD_BITS+1)'(in_ax);
    dy_c[0] = (COORD_BITS+1)'(in_by) - (COORD_BITS+1)'(in_ay);
    dx_c[1] = (COORD_BITS+1)'(in_cx) - (COORD_BITS+1)'(in_ax);
    dy_c[1] = (COORD_BITS+1)'(in_cy) - (COORD_BITS+1)'(in_ay);
    dx_c[2] = (COORD_BITS+1)'(in_cx) - (COORD_BITS+1)'(in_bx);
    dy_c[2] = (COORD_BITS+1)'(in_cy) - (COORD_BITS+1)'(in_by);
    dx_c[3] = (COORD_BITS+1)'(in_ax);
    dy_c[3] = (COORD_BITS+1)'(in_ay);
    dx_c[4] = (COORD_BITS+1)'(in_bx);
    dy_c[4] = (COORD_BITS+1)'(in_by);
    dx_c[5] = (COORD_BITS+1)'(in_cx);
    dy_c[5] = (COORD_BITS+1)'(in_cy);
    for (int l = 0; l < LANES; l++) begin
      adx_c[l] = dx_c[l][COORD_BITS] ? COORD_BITS'(-dx_c[l]) : COORD_BITS'(dx_c[l]);
      ady_c[l] = dy_c[l][COORD_BITS] ? COORD_BITS'(-dy_c[l]) : COORD_BITS'(dy_c[l]);
      rad_c[l] = ((LEN_RAD_W'(adx_c[l]) * LEN_RAD_W'(adx_c[l]))
                + (LEN_RAD_W'(ady_c[l]) * LEN_RAD_W'(ady_c[l]))) << 4;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[PIPE_N-2:0], in_valid};
      out_valid_r <= vld_r[PIPE_N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r <= rad_c;
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_len
    tpa_sqrt_chain #(.RAD_W(LEN_RAD_W)) u_len (
      .clk    (clk),
      .en     (en),
      .rad_i  (rad_r[l]),
      .root_o (len_root[l])
    );
  end

  tpa_heron #(.LEN_W(LEN_ROOT_W)) u_heron (
    .clk     (clk),
    .en      (en),
    .side_ab (len_root[0]),
    .side_ac (len_root[1]),
    .side_bc (len_root[2]),
    .perim_o (perim_h),
    .prod_o  (prod_h)
  );

  tpa_sqrt_chain #(.RAD_W(AREA_RAD_W)) u_area (
    .clk    (clk),
    .en     (en),
    .rad_i  (prod_h),
    .root_o (area_root)
  );

  // Carry lengths and perimeter alongside the area root.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        len_d_r[l][0] <= len_root[l];
        for (int k = 1; k < DLY_N; k++) begin
          len_d_r[l][k] <= len_d_r[l][k-1];
        end
      end
      perim_d_r[0] <= perim_h;
      for (int k = 1; k < AREA_ROOT_W; k++) begin
        perim_d_r[k] <= perim_d_r[k-1];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      len_q[l] = 32'(len_d_r[l][DLY_N-1]);
    end
    perim_q = 32'(perim_d_r[AREA_ROOT_W-1]);
    area_q  = 32'(area_root >> 2);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_ab_r <= (len_q[0] > SIDE_MAX) ? '1 : len_q[0][SIDE_W-1:0];
      side_ac_r <= (len_q[1] > SIDE_MAX) ? '1 : len_q[1][SIDE_W-1:0];
      side_bc_r <= (len_q[2] > SIDE_MAX) ? '1 : len_q[2][SIDE_W-1:0];
      dist_a_r  <= (len_q[3] > DIST_MAX) ? '1 : len_q[3][DIST_W-1:0];
      dist_b_r  <= (len_q[4] > DIST_MAX) ? '1 : len_q[4][DIST_W-1:0];
      dist_c_r  <= (len_q[5] > DIST_MAX) ? '1 : len_q[5][DIST_W-1:0];
      perim_r   <= (perim_q > PERIM_MAX) ? '1 : perim_q[PERIM_W-1:0];
      area_r    <= (area_q > AREA_MAX) ? '1 : area_q[AREA_W-1:0];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_side_ab   = side_ab_r;
  assign out_side_ac   = side_ac_r;
  assign out_side_bc   = side_bc_r;
  assign out_perimeter = perim_r;
  assign out_area      = area_r;
  assign out_dist_a    = dist_a_r;
  assign out_dist_b    = dist_b_r;
  assign out_dist_c    = dist_c_r;

  `TPA_ASSERT_NOW(a_hold_stalls_input, out_valid_r && out_stall, in_stall)
  `TPA_ASSERT_NEXT(a_out_follows_pipe, en, out_valid_r == $past(vld_r[PIPE_N-1]))
  `TPA_ASSERT_NOW(a_flat_zero_area,
    out_valid_r && (side_ab_r == '0) && (side_ac_r == '0), area_r == '0)

endmodule

// ----- verif/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tpa_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam int LATENCY = CB + 41;
  localparam longint CYCLE_LIMIT = 400000;

  typedef logic signed [CB-1:0] coord_t;

  typedef struct packed {
    logic [SIDE_W-1:0]  side_ab;
    logic [SIDE_W-1:0]  side_ac;
    logic [SIDE_W-1:0]  side_bc;
    logic [PERIM_W-1:0] perimeter;
    logic [AREA_W-1:0]  area;
    logic [DIST_W-1:0]  dist_a;
    logic [DIST_W-1:0]  dist_b;
    logic [DIST_W-1:0]  dist_c;
  } measure_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  coord_t in_ax = '0, in_ay = '0, in_bx = '0, in_by = '0, in_cx = '0, in_cy = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [SIDE_W-1:0] out_side_ab, out_side_ac, out_side_bc;
  logic [PERIM_W-1:0] out_perimeter;
  logic [AREA_W-1:0] out_area;
  logic [DIST_W-1:0] out_dist_a, out_dist_b, out_dist_c;

  measure_t expected_measures[$];
  int err_count = 0;
  bit rx_idle_on = 1'b1;
  bit tx_idle_on = 1'b1;
  longint cycle_count = 0;

  triangle_perimeter_area #(.COORD_BITS(CB)) i_dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL triangle_perimeter_area");
      $finish;
    end
  end

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root = 0;
    longint unsigned bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic longint unsigned quarter_len(longint signed dx, longint signed dy);
    return int_sqrt(64'(16 * (dx * dx + dy * dy)));
  endfunction

  function automatic longint unsigned mul_sat(longint unsigned a, longint unsigned b);
    if (a != 0 && b > 64'hFFFF_FFFF_FFFF_FFFF / a) return 64'hFFFF_FFFF_FFFF_FFFF;
    return a * b;
  endfunction

  function automatic longint unsigned heron_term(longint unsigned p, longint unsigned s);
    return (p > 2 * s) ? p - 2 * s : 0;
  endfunction

  function automatic longint unsigned clip(longint unsigned v, longint unsigned m);
    return (v > m) ? m : v;
  endfunction

  function automatic measure_t triangle_measure(coord_t ax, ay, bx, by, cx, cy);
    measure_t m;
    longint unsigned sab, sac, sbc, p, prod;
    sab = quarter_len(longint'(bx) - ax, longint'(by) - ay);
    sac = quarter_len(longint'(cx) - ax, longint'(cy) - ay);
    sbc = quarter_len(longint'(cx) - bx, longint'(cy) - by);
    p = sab + sac + sbc;
    prod = mul_sat(p, heron_term(p, sab));
    prod = mul_sat(prod, heron_term(p, sac));
    prod = mul_sat(prod, heron_term(p, sbc));
    m.side_ab = SIDE_W'(clip(sab, SIDE_MAX));
    m.side_ac = SIDE_W'(clip(sac, SIDE_MAX));
    m.side_bc = SIDE_W'(clip(sbc, SIDE_MAX));
    m.perimeter = PERIM_W'(clip(p, PERIM_MAX));
    m.area = AREA_W'(clip(int_sqrt(prod) >> 2, AREA_MAX));
    m.dist_a = DIST_W'(clip(quarter_len(ax, ay), DIST_MAX));
    m.dist_b = DIST_W'(clip(quarter_len(bx, by), DIST_MAX));
    m.dist_c = DIST_W'(clip(quarter_len(cx, cy), DIST_MAX));
    return m;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", field, got, want, cycle_count);
    err_count++;
  endtask

  // Receiver: random stall bursts, check each result against the oldest prediction.
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (rx_idle_on && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 11);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    measure_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_measures.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        w = expected_measures.pop_front();
        if (out_side_ab !== w.side_ab) report_mismatch("side_ab", out_side_ab, w.side_ab);
        if (out_side_ac !== w.side_ac) report_mismatch("side_ac", out_side_ac, w.side_ac);
        if (out_side_bc !== w.side_bc) report_mismatch("side_bc", out_side_bc, w.side_bc);
        if (out_perimeter !== w.perimeter)
          report_mismatch("perimeter", out_perimeter, w.perimeter);
        if (out_area !== w.area) report_mismatch("area", out_area, w.area);
        if (out_dist_a !== w.dist_a) report_mismatch("dist_a", out_dist_a, w.dist_a);
        if (out_dist_b !== w.dist_b) report_mismatch("dist_b", out_dist_b, w.dist_b);
        if (out_dist_c !== w.dist_c) report_mismatch("dist_c", out_dist_c, w.dist_c);
      end
    end
  end

  // Send one request; hold it until accepted.
  task automatic send_triangle(coord_t ax, ay, bx, by, cx, cy);
    int n;
    if (tx_idle_on && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_ax <= ax; in_ay <= ay; in_bx <= bx; in_by <= by; in_cx <= cx; in_cy <= cy;
    expected_measures.push_back(triangle_measure(ax, ay, bx, by, cx, cy));
    do @(posedge clk); while (in_stall);
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 5))
      0: return coord_t'($urandom_range(0, 15) - 8);
      1: return ($urandom_range(0, 1)) ? coord_t'(-2048) : coord_t'(2047);
      default: return coord_t'($urandom);
    endcase
  endfunction

  task automatic test_extremes();
    coord_t lo, hi;
    lo = coord_t'(-2048);
    hi = coord_t'(2047);
    send_triangle(0, 0, 0, 0, 0, 0);
    send_triangle(lo, lo, hi, hi, lo, hi);
    send_triangle(hi, hi, lo, lo, hi, lo);
    send_triangle(lo, lo, lo, lo, lo, lo);
    send_triangle(hi, hi, hi, hi, hi, hi);
    send_triangle(lo, hi, hi, lo, lo, lo);
    send_triangle(lo, 0, hi, 0, 0, hi);
    send_triangle(0, lo, 0, hi, hi, 0);
    send_triangle(-1, -1, 1, 1, -1, 1);
    send_triangle(coord_t'(12'h555), coord_t'(12'haaa), coord_t'(12'haaa),
                  coord_t'(12'h555), coord_t'(12'h555), coord_t'(12'h555));
  endtask

  function automatic coord_t lo_pt();
    return coord_t'(-2047);
  endfunction

  task automatic test_degenerate();
    send_triangle(0, 0, 3, 4, 6, 8);
    send_triangle(5, 5, 5, 5, 9, -2);
    send_triangle(lo_pt(), 0, 0, 0, 2047, 0);
    send_triangle(-7, 3, -7, 3, -7, 3);
    send_triangle(1, 0, 2, 0, 3, 0);
  endtask

  task automatic test_small_triangles();
    send_triangle(0, 0, 3, 0, 0, 4);
    send_triangle(0, 0, 1, 0, 0, 1);
    send_triangle(0, 0, 2, 0, 1, 2);
    send_triangle(-3, -3, 3, -3, 0, 2);
  endtask

  task automatic test_random(int count);
    repeat (count)
      send_triangle(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                    rand_coord());
  endtask

  initial begin
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_degenerate();
    test_small_triangles();
    test_random(1000);
    // full rate on both sides to finish
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    test_random(250);
    in_valid <= 1'b0;
    while (expected_measures.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (err_count == 0) begin
      $display("PASS triangle_perimeter_area");
    end else begin
      $display("FAIL triangle_perimeter_area");
    end
    $finish;
  end

endmodule
